[rtl/core/pdq_pkg.sv]
package pdq_pkg;

   localparam int SIZE_W = 16;
   localparam int TIME_W = 64;
   localparam int PROC_W = 32;

   typedef enum logic [2:0] {
      CMD_PUSH_BACK     = 3'd0,
      CMD_PUSH_FRONT    = 3'd1,
      CMD_POP_FRONT     = 3'd2,
      CMD_POP_BACK      = 3'd3,
      CMD_PEEK_FRONT    = 3'd4,
      CMD_PEEK_BACK     = 3'd5,
      CMD_SET_PROCESSED = 3'd6
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

endpackage

[rtl/core/packet_deque_with_byte_occupancy_top.sv]
// Channel    Direction  Handshake            Payload
// request    in         start, busy          req_command, req_pkt_size, req_pkt_time,
//                                            req_new_processed
// response   out        rsp_strobe           rsp_out_size, rsp_out_time, rsp_status,
//                                            rsp_length, rsp_occupancy, rsp_processed,
//                                            rsp_is_empty
//
// One command is taken every cycle; busy stays low. Each command gives one
// response: the registered read of the entry memory and the first-stage registers
// come first, then the byte total update and the response register.
// Pointers, entry count and processed count update at the accept edge.
// Reset is synchronous; it empties the queue, the entry memory keeps its contents.
// The response is shown for a single cycle; the receiver cannot stall it.
module packet_deque_with_byte_occupancy_top import pdq_pkg::*; #(
   parameter int  DEPTH = 64,
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W = $clog2(DEPTH + 1),
   localparam int OCC_W = SIZE_W + IDX_W
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [2:0]        req_command,
   input  logic [SIZE_W-1:0] req_pkt_size,
   input  logic [TIME_W-1:0] req_pkt_time,
   input  logic [PROC_W-1:0] req_new_processed,
   output logic              rsp_strobe,
   output logic [SIZE_W-1:0] rsp_out_size,
   output logic [TIME_W-1:0] rsp_out_time,
   output logic [1:0]        rsp_status,
   output logic [CNT_W-1:0]  rsp_length,
   output logic [OCC_W-1:0]  rsp_occupancy,
   output logic [PROC_W-1:0] rsp_processed,
   output logic              rsp_is_empty
);

   // queue state
   logic [IDX_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [PROC_W-1:0] pop_ff, pop_in;
   logic [OCC_W-1:0]  total_ff, total_in;

   // entry memory
   logic [SIZE_W-1:0] size_mem [DEPTH];
   logic [TIME_W-1:0] time_mem [DEPTH];
   logic [SIZE_W-1:0] rd_size_ff;
   logic [TIME_W-1:0] rd_time_ff;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_slot;
   logic [IDX_W-1:0]  rd_slot;

   // first stage
   logic              s1_valid_ff;
   status_type        s1_status_ff, s1_status_in;
   logic              s1_load_ff, s1_load_in;
   logic              s1_add_ff, s1_add_in;
   logic              s1_sub_ff, s1_sub_in;
   logic [SIZE_W-1:0] s1_size_ff;

   // response register
   logic              rsp_strobe_ff;
   logic [SIZE_W-1:0] rsp_size_ff;
   logic [TIME_W-1:0] rsp_time_ff;
   status_type        rsp_status_ff;
   logic [CNT_W-1:0]  rsp_length_ff;
   logic [PROC_W-1:0] rsp_proc_ff;
   logic [CNT_W-1:0]  s1_length_ff;
   logic [PROC_W-1:0] s1_proc_ff;

   cmd_type           cmd;
   logic              accept;
   logic              is_full;
   logic              is_none;
   logic [IDX_W:0]    back_sum;
   logic [IDX_W:0]    last_sum;
   logic [IDX_W-1:0]  back_slot;
   logic [IDX_W-1:0]  last_slot;
   logic [IDX_W-1:0]  last_off;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign cmd    = cmd_type'(req_command);

   assign is_full  = (count_ff == CNT_W'(DEPTH));
   assign is_none  = (count_ff == '0);
   assign last_off = IDX_W'(count_ff - CNT_W'(1));

   // wrap slot offsets from the head around the ring
   always_comb begin
      back_sum = (IDX_W+1)'(head_ff) + (IDX_W+1)'(count_ff[IDX_W-1:0]);
      last_sum = (IDX_W+1)'(head_ff) + (IDX_W+1)'(last_off);
      if (back_sum >= (IDX_W+1)'(DEPTH)) begin
         back_slot = IDX_W'(back_sum - (IDX_W+1)'(DEPTH));
      end else begin
         back_slot = IDX_W'(back_sum);
      end
      if (last_sum >= (IDX_W+1)'(DEPTH)) begin
         last_slot = IDX_W'(last_sum - (IDX_W+1)'(DEPTH));
      end else begin
         last_slot = IDX_W'(last_sum);
      end
   end

   always_comb begin
      head_in      = head_ff;
      count_in     = count_ff;
      pop_in       = pop_ff;
      wr_en        = 1'b0;
      wr_slot      = back_slot;
      rd_slot      = head_ff;
      s1_status_in = ST_OK;
      s1_load_in   = 1'b0;
      s1_add_in    = 1'b0;
      s1_sub_in    = 1'b0;
      if (accept) begin
         unique case (cmd)
            CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
               if (is_full) begin
                  s1_status_in = ST_FULL;
               end else begin
                  wr_en     = 1'b1;
                  s1_add_in = 1'b1;
                  count_in  = count_ff + CNT_W'(1);
                  if (cmd == CMD_PUSH_FRONT) begin
                     head_in = (head_ff == '0) ? IDX_W'(DEPTH - 1) : head_ff - IDX_W'(1);
                     wr_slot = head_in;
                  end
               end
            end
            CMD_POP_FRONT, CMD_POP_BACK, CMD_PEEK_FRONT, CMD_PEEK_BACK: begin
               if (is_none) begin
                  s1_status_in = ST_EMPTY;
               end else begin
                  s1_load_in = 1'b1;
                  if (cmd == CMD_POP_BACK || cmd == CMD_PEEK_BACK) begin
                     rd_slot = last_slot;
                  end
                  if (cmd == CMD_POP_FRONT) begin
                     head_in = (head_ff == IDX_W'(DEPTH - 1)) ? '0 : head_ff + IDX_W'(1);
                     pop_in  = pop_ff + PROC_W'(1);
                  end
                  if (cmd == CMD_POP_FRONT || cmd == CMD_POP_BACK) begin
                     s1_sub_in = 1'b1;
                     count_in  = count_ff - CNT_W'(1);
                  end
               end
            end
            CMD_SET_PROCESSED: begin
               pop_in = req_new_processed;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         size_mem[wr_slot] <= req_pkt_size;
         time_mem[wr_slot] <= req_pkt_time;
      end
      rd_size_ff <= size_mem[rd_slot];
      rd_time_ff <= time_mem[rd_slot];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         count_ff    <= '0;
         pop_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         head_ff     <= head_in;
         count_ff    <= count_in;
         pop_ff      <= pop_in;
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      s1_status_ff <= s1_status_in;
      s1_load_ff   <= s1_load_in;
      s1_add_ff    <= s1_add_in;
      s1_sub_ff    <= s1_sub_in;
      s1_size_ff   <= req_pkt_size;
      s1_length_ff <= count_in;
      s1_proc_ff   <= pop_in;
   end

   // apply the byte delta: add the pushed size, or subtract the popped size once it is back from memory
   always_comb begin
      total_in = total_ff;
      if (s1_valid_ff) begin
         if (s1_add_ff) begin
            total_in = total_ff + OCC_W'(s1_size_ff);
         end else if (s1_sub_ff) begin
            total_in = total_ff - OCC_W'(rd_size_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         total_ff      <= total_in;
         rsp_strobe_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_size_ff   <= s1_load_ff ? rd_size_ff : '0;
      rsp_time_ff   <= s1_load_ff ? rd_time_ff : '0;
      rsp_status_ff <= s1_status_ff;
      rsp_length_ff <= s1_length_ff;
      rsp_proc_ff   <= s1_proc_ff;
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_out_size  = rsp_size_ff;
   assign rsp_out_time  = rsp_time_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_length    = rsp_length_ff;
   assign rsp_occupancy = total_ff;
   assign rsp_processed = rsp_proc_ff;
   assign rsp_is_empty  = (rsp_length_ff == '0);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count beyond depth");

   a_strobe_follows_start: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |=> rsp_strobe)
      else $error("response lost after first stage");

   a_full_length: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status == ST_FULL |-> rsp_length == CNT_W'(DEPTH))
      else $error("full status with room left");

   a_empty_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status == ST_EMPTY |-> rsp_is_empty && rsp_out_size == '0
         && rsp_out_time == '0)
      else $error("empty status with entry data");

   a_empty_no_bytes: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_is_empty |-> rsp_occupancy == '0)
      else $error("bytes counted in empty queue");

endmodule
